// File: hdl/mm64_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mm64_pkg
// Shared types and constants for the MurmurHash64A stream hash: the mixing
// constant, the queue entry that links the front end to the back end, the
// multiplier request and response, and the back-end sequencer states.
// ---------------------------------------------------------------------------
package mm64_pkg;

   // Mixing multiplier and the xor-shift distance of the scheme.
   localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
   localparam int          MIX_SHIFT = 47;

   // Halves of the multiplier, fed to the shared 32 x 32 unit.
   localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
   localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];

   // Default number of entries in the queue between front and back end.
   localparam int MM64_QUEUE_DEPTH = 2;

   // How one word contributes to the running hash.
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_FULL,
      KIND_TAIL
   } mm64_kind_type;

   // One classified word, as queued for the back end.
   typedef struct packed {
      logic [63:0]   word;
      mm64_kind_type kind;
      logic          first;
      logic          last;
      logic [31:0]   length;
   } mm64_entry_type;

   // Request to and response from the shared multiplier.
   typedef struct packed {
      logic        start;
      logic [63:0] operand;
   } mm64_mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] product;
   } mm64_mul_rsp_type;

   // Partial-product phases of the multiplier.
   typedef enum logic [1:0] {
      PH_LOW,
      PH_HIGH_A,
      PH_HIGH_M
   } mm64_phase_type;

   // Back-end sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_LEN_GO,
      S_LEN_WAIT,
      S_DISPATCH,
      S_K1_GO,
      S_K1_WAIT,
      S_K2_GO,
      S_K2_WAIT,
      S_H_GO,
      S_H_WAIT,
      S_FIN_GO,
      S_FIN_WAIT
   } mm64_state_type;

   // Xor-shift step used in key mixing and finalisation.
   function automatic logic [63:0] xor_shift(input logic [63:0] value);
      xor_shift = value ^ (value >> MIX_SHIFT);
   endfunction

endpackage
`default_nettype wire

// File: hdl/mm64_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mm64_front
// Request front end: accepts word beats, drops words that arrive outside a
// message, classifies the rest as full, tail or empty and queues them.
// ---------------------------------------------------------------------------
module mm64_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire  [63:0]          req_data_word,
   input  wire  [3:0]           req_byte_count,
   input  wire                  req_first_word,
   input  wire                  req_last_word,
   input  wire  [31:0]          req_message_length,
   output logic                 push_valid,
   input  wire                  push_ready,
   output mm64_pkg::mm64_entry_type push_entry
);
   import mm64_pkg::*;

   logic        in_message_ff;
   logic        in_message_in;
   logic        accept;
   logic        keep;
   logic [63:0] byte_mask;

   // The queue sets the pace; dropped beats are taken at the same rate.
   assign req_ready = push_ready;
   assign accept    = req_valid & req_ready;
   assign keep      = req_first_word | in_message_ff;

   // Message tracking follows the beats in arrival order.
   always_comb begin
      in_message_in = in_message_ff;
      if (accept && keep) begin
         in_message_in = ~req_last_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_message_ff <= 1'b0;
      end else begin
         in_message_ff <= in_message_in;
      end
   end

   // Keep the bytes below the count of a short word.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         byte_mask[8*i +: 8] = (4'(i) < req_byte_count) ? 8'hff : 8'h00;
      end
   end

   // Classify the word and build the queue entry.
   always_comb begin
      push_valid        = accept & keep;
      push_entry.first  = req_first_word;
      push_entry.last   = req_last_word;
      push_entry.length = req_message_length;
      if (req_byte_count[3]) begin
         push_entry.kind = KIND_FULL;
         push_entry.word = req_data_word;
      end else if (req_byte_count == 4'd0) begin
         push_entry.kind = KIND_NONE;
         push_entry.word = req_data_word;
      end else begin
         push_entry.kind = KIND_TAIL;
         push_entry.word = req_data_word & byte_mask;
      end
   end

endmodule
`default_nettype wire

// File: hdl/mm64_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mm64_queue
// Short first-in first-out queue of classified words between the front
// end and the back end.
// ---------------------------------------------------------------------------
module mm64_queue #(
   parameter int DEPTH = mm64_pkg::MM64_QUEUE_DEPTH
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push_valid,
   output logic                     push_ready,
   input  mm64_pkg::mm64_entry_type push_entry,
   output logic                     pop_valid,
   input  wire                      pop_ready,
   output mm64_pkg::mm64_entry_type pop_entry
);
   import mm64_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mm64_entry_type   entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // Pointer and fill-count update with wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // The fill count never passes the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count beyond depth");

   // Full and empty at once cannot happen.
   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      push_ready || pop_valid)
      else $error("queue reports full and empty together");

   // A pop leaves one entry fewer unless a push came with it.
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not follow a pop");

endmodule
`default_nettype wire

// File: hdl/mm64_mul.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mm64_mul
// Multiplier by the mixing constant, truncated to 64 bits. One 32 x 32
// unit forms, one after another, the three partial products that reach
// the low 64 bits.
// ---------------------------------------------------------------------------
module mm64_mul (
   input  wire                        clock,
   input  wire                        reset,
   input  mm64_pkg::mm64_mul_req_type mul_req,
   output mm64_pkg::mm64_mul_rsp_type mul_rsp
);
   import mm64_pkg::*;

   logic           busy_ff;
   logic           busy_in;
   logic           done_ff;
   logic           done_in;
   mm64_phase_type phase_ff;
   mm64_phase_type phase_in;
   logic [63:0]    operand_ff;
   logic [63:0]    operand_in;
   logic [63:0]    acc_ff;
   logic [63:0]    acc_in;
   logic [31:0]    mul_a;
   logic [31:0]    mul_b;
   logic [63:0]    partial;

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= PH_LOW;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      operand_ff <= operand_in;
      acc_ff     <= acc_in;
   end

   // Low by low, then the two cross terms shifted into the upper half.
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      phase_in   = phase_ff;
      operand_in = operand_ff;
      acc_in     = acc_ff;
      mul_a      = (phase_ff == PH_HIGH_A) ? operand_ff[63:32] : operand_ff[31:0];
      mul_b      = (phase_ff == PH_HIGH_M) ? MIX_MUL_HI : MIX_MUL_LO;
      partial    = mul_a * mul_b;
      if (busy_ff) begin
         case (phase_ff)
            PH_LOW: begin
               acc_in   = partial;
               phase_in = PH_HIGH_A;
            end
            PH_HIGH_A: begin
               acc_in   = acc_ff + {partial[31:0], 32'h0};
               phase_in = PH_HIGH_M;
            end
            PH_HIGH_M: begin
               acc_in   = acc_ff + {partial[31:0], 32'h0};
               phase_in = PH_LOW;
               busy_in  = 1'b0;
               done_in  = 1'b1;
            end
            default: begin
               phase_in = PH_LOW;
               busy_in  = 1'b0;
            end
         endcase
      end else if (mul_req.start) begin
         operand_in = mul_req.operand;
         phase_in   = PH_LOW;
         busy_in    = 1'b1;
      end
   end

   // A new product is only requested while the unit is free.
   a_start_free: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |-> !busy_ff)
      else $error("multiplier started while busy");

   // Completion is seen after a start once the three partial-product phases have run and done is registered.
   a_done_latency: assert property (@(posedge clock) disable iff (reset)
      (mul_req.start && !busy_ff) |-> ##4 done_ff)
      else $error("multiplier result late");

endmodule
`default_nettype wire

// File: hdl/mm64_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mm64_back
// Hash back end: holds the seed and running hash, takes classified words
// from the queue, sequences the multiplies for seeding, key mixing, hash
// update and finalisation, and drives the response register.
// ---------------------------------------------------------------------------
module mm64_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      csr_valid,
   input  wire  [63:0]              csr_seed,
   input  wire                      pop_valid,
   output logic                     pop_ready,
   input  mm64_pkg::mm64_entry_type pop_entry,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output logic [63:0]              rsp_hash_value
);
   import mm64_pkg::*;

   mm64_state_type   state_ff;
   mm64_state_type   state_in;
   logic [63:0]      seed_ff;
   logic [63:0]      hash_ff;
   logic [63:0]      hash_in;
   mm64_entry_type   cur_ff;
   mm64_entry_type   cur_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [63:0]      rsp_hash_ff;
   logic [63:0]      rsp_hash_in;
   logic             slot_free;
   mm64_mul_req_type mul_req;
   mm64_mul_rsp_type mul_rsp;

   mm64_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;
   assign slot_free      = !rsp_valid_ff || rsp_ready;

   // Seed register; the user is to write it only while the block is idle, which the block itself does not enforce.
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_valid) begin
         seed_ff <= csr_seed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hash_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   // Sequencer: one multiply at a time through the shared unit.
   always_comb begin
      state_in        = state_ff;
      hash_in         = hash_ff;
      cur_in          = cur_ff;
      rsp_hash_in     = rsp_hash_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      pop_ready       = 1'b0;
      mul_req.start   = 1'b0;
      mul_req.operand = cur_ff.word;
      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               pop_ready = 1'b1;
               cur_in    = pop_entry;
               state_in  = pop_entry.first ? S_LEN_GO : S_DISPATCH;
            end
         end
         S_LEN_GO: begin
            mul_req.start   = 1'b1;
            mul_req.operand = {32'h0, cur_ff.length};
            state_in        = S_LEN_WAIT;
         end
         S_LEN_WAIT: begin
            if (mul_rsp.done) begin
               hash_in  = seed_ff ^ mul_rsp.product;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (cur_ff.kind)
               KIND_FULL: begin
                  state_in = S_K1_GO;
               end
               KIND_TAIL: begin
                  hash_in  = hash_ff ^ cur_ff.word;
                  state_in = S_H_GO;
               end
               default: begin
                  state_in = cur_ff.last ? S_FIN_GO : S_IDLE;
               end
            endcase
         end
         S_K1_GO: begin
            mul_req.start = 1'b1;
            state_in      = S_K1_WAIT;
         end
         S_K1_WAIT: begin
            if (mul_rsp.done) begin
               cur_in.word = xor_shift(mul_rsp.product);
               state_in    = S_K2_GO;
            end
         end
         S_K2_GO: begin
            mul_req.start = 1'b1;
            state_in      = S_K2_WAIT;
         end
         S_K2_WAIT: begin
            if (mul_rsp.done) begin
               hash_in  = hash_ff ^ mul_rsp.product;
               state_in = S_H_GO;
            end
         end
         S_H_GO: begin
            mul_req.start   = 1'b1;
            mul_req.operand = hash_ff;
            state_in        = S_H_WAIT;
         end
         S_H_WAIT: begin
            if (mul_rsp.done) begin
               hash_in  = mul_rsp.product;
               state_in = cur_ff.last ? S_FIN_GO : S_IDLE;
            end
         end
         S_FIN_GO: begin
            // Finalise only once the response register has room.
            if (slot_free) begin
               mul_req.start   = 1'b1;
               mul_req.operand = xor_shift(hash_ff);
               state_in        = S_FIN_WAIT;
            end
         end
         S_FIN_WAIT: begin
            if (mul_rsp.done) begin
               rsp_hash_in  = xor_shift(mul_rsp.product);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Products arrive only while the sequencer waits for one.
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == S_LEN_WAIT || state_ff == S_K1_WAIT ||
                        state_ff == S_K2_WAIT || state_ff == S_H_WAIT ||
                        state_ff == S_FIN_WAIT))
      else $error("multiplier result outside a wait state");

   // The response register is empty while a finalisation is in flight.
   a_slot_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN_WAIT) |-> !rsp_valid_ff)
      else $error("response register busy during finalisation");

   // A response appears only at the end of finalisation.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN_WAIT))
      else $error("response raised outside finalisation");

endmodule
`default_nettype wire

// File: hdl/murmur64a_stream_hash.sv
`default_nettype none
// ---------------------------------------------------------------------------
// murmur64a_stream_hash
// MurmurHash64A over a stream of 64-bit little-endian words with a seed
// register. A front end classifies word beats into a short queue; a back
// end mixes them through a shared multiplier and returns the final hash.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid / req_ready  data_word, byte_count,
//                                              first_word, last_word,
//                                              message_length
//   rsp_     out        rsp_valid / rsp_ready  hash_value
//   csr_     in         csr_valid / csr_ready  seed
//
// Each 64-bit multiply on the shared 32 x 32 multiplier runs through issue,
// three partial products and the state that takes the product.
// A word goes through queue pop and dispatch, then its multiplies:
// three for a full word, one for a short word, none for an empty one; a
// first word adds one, a last word one.
// Reset clears the seed, the running hash, the queue and the response.
// The front end keeps taking beats while the queue has room, so a stalled
// response holds only the back end; csr_ready is always high.
//
module murmur64a_stream_hash #(
   parameter int QUEUE_DEPTH = mm64_pkg::MM64_QUEUE_DEPTH
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [63:0] req_data_word,
   input  wire  [3:0]  req_byte_count,
   input  wire         req_first_word,
   input  wire         req_last_word,
   input  wire  [31:0] req_message_length,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [63:0] rsp_hash_value,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [63:0] csr_seed
);
   import mm64_pkg::*;

   logic           push_valid;
   logic           push_ready;
   mm64_entry_type push_entry;
   logic           pop_valid;
   logic           pop_ready;
   mm64_entry_type pop_entry;

   assign csr_ready = 1'b1;

   // Front end: accept and classify beats.
   mm64_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .req_first_word     (req_first_word),
      .req_last_word      (req_last_word),
      .req_message_length (req_message_length),
      .push_valid         (push_valid),
      .push_ready         (push_ready),
      .push_entry         (push_entry)
   );

   // Queue between the two halves.
   mm64_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Back end: mixing, finalisation and response.
   mm64_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid & csr_ready),
      .csr_seed       (csr_seed),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_entry      (pop_entry),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for murmur64a_stream_hash. Word beats go in through
// the request channel and a local model of the hash predicts the finalised
// value of every closed message. Each hash beat is checked against the
// oldest prediction. Directed messages cover sizes, framing and seed
// extremes. A long response hold-off fills the block. Random traffic,
// mostly well-formed messages, is run under several seeds.
// ---------------------------------------------------------------------------
module testbench;
   import mm64_pkg::MIX_MUL;
   import mm64_pkg::MIX_SHIFT;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 5;
   // A word costs at most five multiplies in the back end, and a few may
   // still sit in the queue behind the last hash.
   localparam int DRAIN_CYCLES = 150;
   localparam int STALL_LIMIT  = 5000;
   localparam int LONG_HOLD    = 400;
   localparam int RANDOM_WORDS = 1950;
   localparam int PHASES       = 4;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   // One word beat as the request channel carries it.
   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  count;
      logic        first_word;
      logic        last_word;
      logic [31:0] length;
   } hash_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_data_word = '0;
   logic [3:0]  req_byte_count = '0;
   logic        req_first_word = 1'b0;
   logic        req_last_word = 1'b0;
   logic [31:0] req_message_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_hash_value;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [63:0] csr_seed = '0;

   // Model state of the hash and the results still owed by the block.
   logic [63:0] seed_model = '0;
   logic [63:0] hash_model = '0;
   bit          msg_open = 1'b0;
   logic [63:0] pending_hashes[$];
   logic [63:0] want_hash;

   int error_count = 0;
   int words_counted = 0;
   int quiet_cycles = 0;
   int hold_request = 0;
   int stall_left = 0;
   bit idle_on = 1'b1;

   murmur64a_stream_hash u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .req_first_word     (req_first_word),
      .req_last_word      (req_last_word),
      .req_message_length (req_message_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hash_value     (rsp_hash_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_seed           (csr_seed)
   );

   always #HALF_PERIOD clock = ~clock;

   // Prints one line per mismatch and keeps the tally.
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH at %0t: %s: got %h, expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic hash_word_type word_of(input logic [63:0] data,
                                             input logic [3:0] count,
                                             input bit first_word, input bit last_word,
                                             input logic [31:0] length);
      hash_word_type w;
      w.data       = data;
      w.count      = count;
      w.first_word = first_word;
      w.last_word  = last_word;
      w.length     = length;
      return w;
   endfunction

   // Folds one accepted word into the model hash. Returns 0 when the block
   // ignores the word because no message is open.
   function automatic bit advance_hash(input hash_word_type w);
      logic [63:0] h;
      logic [63:0] k;
      logic [63:0] keep;
      if (!w.first_word && !msg_open) begin
         return 1'b0;
      end
      h = w.first_word ? (seed_model ^ (64'(w.length) * MIX_MUL)) : hash_model;
      if (w.count >= 4'd8) begin
         k = w.data * MIX_MUL;
         k = k ^ (k >> MIX_SHIFT);
         k = k * MIX_MUL;
         h = (h ^ k) * MIX_MUL;
      end else if (w.count != 4'd0) begin
         keep = (64'd1 << (w.count[2:0] * 8)) - 64'd1;
         h = (h ^ (w.data & keep)) * MIX_MUL;
      end
      hash_model = h;
      msg_open = !w.last_word;
      // The last word closes the message and owes a finalised hash.
      if (w.last_word) begin
         h = h ^ (h >> MIX_SHIFT);
         h = h * MIX_MUL;
         h = h ^ (h >> MIX_SHIFT);
         pending_hashes.push_back(h);
      end
      return 1'b1;
   endfunction

   // Offers one word beat, waits for it to be taken and updates the model.
   // Valid is left high so that a following beat can go out back to back.
   task automatic send_word(input hash_word_type w);
      if (idle_on && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data_word      <= w.data;
      req_byte_count     <= w.count;
      req_first_word     <= w.first_word;
      req_last_word      <= w.last_word;
      req_message_length <= w.length;
      do @(posedge clock); while (!req_ready);
      if (advance_hash(w)) begin
         words_counted++;
      end
   endtask

   // Lets the block run dry: every hash delivered, then the queue drained.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_seed  <= value;
      do @(posedge clock); while (!csr_ready);
      seed_model = value;
      csr_valid <= 1'b0;
   endtask

   // Every byte count on a one-word message, with extreme data and lengths,
   // under the reset seed.
   task automatic test_single_words();
      int c;
      send_word(word_of('0, 4'd0, 1'b1, 1'b1, 32'd0));
      for (c = 1; c <= 8; c++) begin
         send_word(word_of(ALL_ONES, 4'(c), 1'b1, 1'b1, 32'(c)));
      end
      send_word(word_of(64'h0123_4567_89AB_CDEF, 4'd15, 1'b1, 1'b1, 32'hFFFF_FFFF));
      send_word(word_of('0, 4'd8, 1'b1, 1'b1, 32'd8));
      wait_idle();
   endtask

   // Stray words, short words inside a message, restarts and saturation.
   task automatic test_message_framing();
      // Words outside a message are dropped, even with the last flag.
      send_word(word_of(64'hDEAD_BEEF_0000_0001, 4'd8, 1'b0, 1'b1, 32'd8));
      send_word(word_of(64'hDEAD_BEEF_0000_0002, 4'd3, 1'b0, 1'b0, 32'd3));
      // A short word that is not the last is mixed as a tail and the message goes on.
      send_word(word_of(64'h1122_3344_5566_7788, 4'd5, 1'b1, 1'b0, 32'd13));
      send_word(word_of(ALL_ONES, 4'd8, 1'b0, 1'b1, 32'd0));
      // A first word inside a message throws the open one away.
      send_word(word_of(64'hAAAA_5555_AAAA_5555, 4'd8, 1'b1, 1'b0, 32'd24));
      send_word(word_of(64'h5555_AAAA_5555_AAAA, 4'd8, 1'b0, 1'b0, 32'd0));
      send_word(word_of(64'h0F0F_0F0F_0F0F_0F0F, 4'd2, 1'b1, 1'b1, 32'd2));
      // Counts above eight saturate, on a first and on a last word.
      send_word(word_of(64'hFEDC_BA98_7654_3210, 4'd12, 1'b1, 1'b0, 32'hFFFF_FFFF));
      send_word(word_of(ALL_ONES, 4'd9, 1'b0, 1'b1, 32'd0));
      wait_idle();
   endtask

   // Seed extremes and zero, each on a short and a two-word message.
   task automatic test_seed_extremes();
      logic [63:0] seeds[4];
      int i;
      seeds[0] = ALL_ONES;
      seeds[1] = 64'h8000_0000_0000_0000;
      seeds[2] = 64'h0000_0000_0000_0001;
      seeds[3] = '0;
      for (i = 0; i < 4; i++) begin
         write_seed(seeds[i]);
         send_word(word_of(64'h0000_0000_0000_00A5, 4'd1, 1'b1, 1'b1, 32'd1));
         send_word(word_of(ALL_ONES, 4'd8, 1'b1, 1'b0, 32'd11));
         send_word(word_of(64'h0000_0000_0012_3456, 4'd3, 1'b0, 1'b1, 32'd0));
         wait_idle();
      end
   endtask

   // The receiver holds off long enough for the block to fill and stall.
   task automatic test_back_pressure();
      int m;
      int i;
      idle_on = 1'b0;
      hold_request = LONG_HOLD;
      for (m = 0; m < 4; m++) begin
         for (i = 0; i < 3; i++) begin
            send_word(word_of({$urandom, $urandom}, 4'd8, i == 0, i == 2, 32'd24));
         end
      end
      idle_on = 1'b1;
      wait_idle();
   endtask

   // One random message, now and then broken off or replaced by a stray beat.
   task automatic send_random_message();
      int pick;
      int n;
      int i;
      logic [3:0] tail_count;
      logic [3:0] count;
      logic [63:0] data;
      logic [31:0] length;
      bit broken;
      pick = $urandom_range(99);
      if (pick < 5 && !msg_open) begin
         send_word(word_of({$urandom, $urandom}, 4'($urandom_range(15)), 1'b0,
                           1'($urandom_range(1)), $urandom));
         return;
      end
      n = (pick < 12) ? $urandom_range(6, 12) : $urandom_range(1, 4);
      broken = (pick >= 12 && pick < 20 && n > 1);
      tail_count = ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(8));
      length = ($urandom_range(99) < 60) ? 32'((n - 1) * 8 + tail_count) : $urandom;
      for (i = 0; i < n - (broken ? 1 : 0); i++) begin
         case ($urandom_range(19))
            0: data = '0;
            1: data = ALL_ONES;
            default: data = {$urandom, $urandom};
         endcase
         if (i == n - 1) begin
            count = tail_count;
         end else if ($urandom_range(19) == 0) begin
            count = 4'($urandom_range(15));
         end else begin
            count = 4'd8;
         end
         send_word(word_of(data, count, i == 0, i == n - 1, length));
      end
   endtask

   // Random traffic in phases, each under its own seed; the second phase
   // runs with neither side idling.
   task automatic test_random_traffic();
      int phase;
      int start;
      for (phase = 0; phase < PHASES; phase++) begin
         write_seed((phase == PHASES - 1) ? ALL_ONES : {$urandom, $urandom});
         idle_on = (phase != 1);
         start = words_counted;
         while (words_counted - start < RANDOM_WORDS / PHASES) begin
            send_random_message();
         end
         wait_idle();
      end
      idle_on = 1'b1;
   endtask

   // Receiver: random stalls, or a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(idle_on && $urandom_range(99) < 24);
      end
   end

   // Each hash beat is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_hashes.size() == 0) begin
            report_mismatch("hash beat with nothing expected", rsp_hash_value, '0);
         end else begin
            want_hash = pending_hashes.pop_front();
            if (rsp_hash_value !== want_hash) begin
               report_mismatch("hash_value", rsp_hash_value, want_hash);
            end
         end
      end
   end

   // Watchdog: ends the run when no beat moves on any channel for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_single_words();
      test_message_framing();
      test_seed_extremes();
      test_back_pressure();
      test_random_traffic();
      if (pending_hashes.size() != 0) begin
         report_mismatch("hashes never delivered", '0, 64'(pending_hashes.size()));
      end
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
